### rtl/core/dotq_pkg.sv
// dotq_pkg: types, codes and constants shared by the timer queue modules.
// No dependencies; imported by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package dotq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TAG_BITS_DEF    = 16;
  localparam int unsigned MAX_RESULTS     = 16;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned PEND_W   = 5;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned RESCNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INS_ABS   = 2'd0,
    FUNC_INS_DELAY = 2'd1,
    FUNC_TICK      = 2'd2,
    FUNC_CLEAR     = 2'd3
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERTED = 3'd0,
    KIND_REJECTED = 3'd1,
    KIND_DUE      = 3'd2,
    KIND_NOTHING  = 3'd3,
    KIND_CLEARED  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_INS,
    ST_POP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic  load;      // capture the input item
    logic  calc;      // form the deadline of an insert
    logic  tick_inc;  // advance the millisecond counter, restart result count
    logic  ins;       // insert into the sorted slots
    logic  pop;       // remove the head slot
    logic  clr;       // drop every task
    logic  emit;      // present a result next cycle
    kind_e kind;
    logic  last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_e func;
    logic  full;
    logic  due;       // head task is due and the per-tick limit is not reached
    logic  due_last;  // the due task now at the head ends this tick
  } dp_status_t;

endpackage

### rtl/core/dotq_ctrl.sv
// dotq_ctrl: sequencing state machine of the timer queue.
// Depends on dotq_pkg; drives the datapath by dp_cmd_t and reads dp_status_t.
`timescale 1ns / 1ps

module dotq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  dotq_pkg::dp_status_t status_i,
  output dotq_pkg::dp_cmd_t    cmd_o
);
  import dotq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.kind = KIND_INSERTED;
    busy_o  = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        case (status_i.func)
          FUNC_INS_ABS, FUNC_INS_DELAY: begin
            cmd_o.calc = 1'b1;
            state_d    = ST_INS;
          end
          FUNC_TICK: begin
            cmd_o.tick_inc = 1'b1;
            state_d        = ST_POP;
          end
          default: begin
            cmd_o.clr  = 1'b1;
            cmd_o.emit = 1'b1;
            cmd_o.kind = KIND_CLEARED;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        endcase
      end
      ST_INS: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = 1'b1;
        if (status_i.full) begin
          cmd_o.kind = KIND_REJECTED;
        end else begin
          cmd_o.ins  = 1'b1;
          cmd_o.kind = KIND_INSERTED;
        end
        state_d = ST_IDLE;
      end
      ST_POP: begin
        cmd_o.emit = 1'b1;
        if (status_i.due) begin
          cmd_o.pop  = 1'b1;
          cmd_o.kind = KIND_DUE;
          cmd_o.last = status_i.due_last;
          if (status_i.due_last) begin
            state_d = ST_IDLE;
          end
        end else begin
          // only reached before the first due task of this tick
          cmd_o.kind = KIND_NOTHING;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/dotq_dp.sv
// dotq_dp: sorted slot array, counters and result register of the timer queue.
// Depends on dotq_pkg; commanded by dotq_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module dotq_dp #(
  parameter int unsigned QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_BITS    = dotq_pkg::TAG_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dotq_pkg::FUNC_W-1:0]   func_i,
  input  logic [dotq_pkg::TIME_W-1:0]   time_value_i,
  input  logic [dotq_pkg::TAG_W-1:0]    task_tag_i,
  input  dotq_pkg::dp_cmd_t             cmd_i,
  output dotq_pkg::dp_status_t          status_o,
  output logic                          valid_o,
  output logic [dotq_pkg::KIND_W-1:0]   kind_o,
  output logic [dotq_pkg::TAG_W-1:0]    due_tag_o,
  output logic [dotq_pkg::TIME_W-1:0]   due_time_o,
  output logic [dotq_pkg::PEND_W-1:0]   pending_count_o,
  output logic                          is_last_o
);
  import dotq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // captured item
  func_e               func_q;
  logic [TIME_W-1:0]   time_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [TIME_W-1:0]   when_q;

  // control state
  logic [CW-1:0]       count_q;
  logic [TIME_W-1:0]   now_q;
  logic [RESCNT_W-1:0] n_q;

  // slot cells
  logic [TIME_W-1:0]   dl_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tg_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ins_at;
  logic [QUEUE_DEPTH-1:0] ins_prev;
  logic [TIME_W-1:0]   up_dl   [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] up_tg   [QUEUE_DEPTH];
  logic [TIME_W-1:0]   down_dl [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] down_tg [QUEUE_DEPTH];

  logic [TIME_W:0]     sum_w;
  logic [TIME_W-1:0]   sat_when;
  logic [CW-1:0]       count_inc;
  logic [CW-1:0]       count_dec;

  assign sum_w     = {1'b0, now_q} + {1'b0, time_q};
  assign sat_when  = sum_w[TIME_W] ? '1 : sum_w[TIME_W-1:0];
  assign count_inc = count_q + CW'(1);
  assign count_dec = count_q - CW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
      time_q <= time_value_i;
      tag_q  <= TAG_BITS'(task_tag_i);
    end
    if (cmd_i.calc) begin
      when_q <= (func_q == FUNC_INS_DELAY) ? sat_when : time_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      now_q   <= '0;
      n_q     <= '0;
    end else begin
      if (cmd_i.clr) begin
        count_q <= '0;
      end else if (cmd_i.ins) begin
        count_q <= count_inc;
      end else if (cmd_i.pop) begin
        count_q <= count_dec;
      end
      if (cmd_i.tick_inc) begin
        if (now_q != '1) begin
          now_q <= now_q + TIME_W'(1);
        end
        n_q <= '0;
      end else if (cmd_i.pop) begin
        n_q <= n_q + RESCNT_W'(1);
      end
    end
  end

  // Each cell sees its neighbours only. Slots are sorted, so ins_at is a
  // run of zeros then ones: the first one takes the new task, the rest shift up.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign ins_at[g] = (CW'(g) >= count_q) || (dl_q[g] > when_q);
    if (g == 0) begin : g_head
      assign ins_prev[g] = 1'b0;
      assign up_dl[g]    = when_q;
      assign up_tg[g]    = tag_q;
    end else begin : g_body
      assign ins_prev[g] = ins_at[g-1];
      assign up_dl[g]    = dl_q[g-1];
      assign up_tg[g]    = tg_q[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign down_dl[g] = dl_q[g];
      assign down_tg[g] = tg_q[g];
    end else begin : g_inner
      assign down_dl[g] = dl_q[g+1];
      assign down_tg[g] = tg_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.ins && ins_at[g]) begin
        dl_q[g] <= ins_prev[g] ? up_dl[g] : when_q;
        tg_q[g] <= ins_prev[g] ? up_tg[g] : tag_q;
      end else if (cmd_i.pop) begin
        dl_q[g] <= down_dl[g];
        tg_q[g] <= down_tg[g];
      end
    end
  end

  always_comb begin
    status_o.func     = func_q;
    status_o.full     = (count_q == CW'(QUEUE_DEPTH));
    status_o.due      = (count_q != '0) && (dl_q[0] <= now_q)
                        && (n_q != RESCNT_W'(MAX_RESULTS));
    status_o.due_last = (n_q == RESCNT_W'(MAX_RESULTS - 1)) || (count_q == CW'(1))
                        || (dl_q[1] > now_q);
  end

  // result register: one cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_o    <= cmd_i.kind;
      is_last_o <= cmd_i.last;
      case (cmd_i.kind)
        KIND_INSERTED: begin
          due_tag_o       <= TAG_W'(tag_q);
          due_time_o      <= when_q;
          pending_count_o <= PEND_W'(count_inc);
        end
        KIND_REJECTED: begin
          due_tag_o       <= TAG_W'(tag_q);
          due_time_o      <= when_q;
          pending_count_o <= PEND_W'(count_q);
        end
        KIND_DUE: begin
          due_tag_o       <= TAG_W'(tg_q[0]);
          due_time_o      <= dl_q[0];
          pending_count_o <= PEND_W'(count_dec);
        end
        KIND_NOTHING: begin
          due_tag_o       <= '0;
          due_time_o      <= now_q;
          pending_count_o <= PEND_W'(count_q);
        end
        default: begin
          due_tag_o       <= '0;
          due_time_o      <= '0;
          pending_count_o <= '0;
        end
      endcase
    end
  end

endmodule

### rtl/core/deadline_ordered_timer_queue.sv
// Channel   Handshake                         Fields
// command   start in, busy out; start & !busy  func_i, time_value_i, task_tag_i
// result    valid_o strobe, one cycle          kind_o, due_tag_o, due_time_o,
//                                              pending_count_o, is_last_o
//
// Insert: ST_PREP forms the deadline, then ST_INS writes the slot and emits the result;
// the insert compares every slot in parallel and shifts within the single ST_INS state.
// Clear: done in ST_PREP. Tick: ST_PREP advances the counter, then k due tasks (k up to 16), one per cycle
// from the head slot; a tick with nothing due gives one result of kind nothing.
// A new item may be accepted in the cycle its predecessor's last result shows.
// Reset clears the task count and the millisecond counter; slots need no clearing.
// Results cannot be stalled.
//
// Top level of the sorted timer queue: instantiates dotq_ctrl and dotq_dp, uses dotq_pkg.
`timescale 1ns / 1ps

module deadline_ordered_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_BITS    = dotq_pkg::TAG_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [dotq_pkg::FUNC_W-1:0]   func_i,
  input  logic [dotq_pkg::TIME_W-1:0]   time_value_i,
  input  logic [dotq_pkg::TAG_W-1:0]    task_tag_i,
  output logic                          valid_o,
  output logic [dotq_pkg::KIND_W-1:0]   kind_o,
  output logic [dotq_pkg::TAG_W-1:0]    due_tag_o,
  output logic [dotq_pkg::TIME_W-1:0]   due_time_o,
  output logic [dotq_pkg::PEND_W-1:0]   pending_count_o,
  output logic                          is_last_o
);
  import dotq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dotq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  dotq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .func_i          (func_i),
    .time_value_i    (time_value_i),
    .task_tag_i      (task_tag_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .valid_o         (valid_o),
    .kind_o          (kind_o),
    .due_tag_o       (due_tag_o),
    .due_time_o      (due_time_o),
    .pending_count_o (pending_count_o),
    .is_last_o       (is_last_o)
  );

endmodule

### rtl/core/dotq_checker.sv
// dotq_checker: port-level assertions on the timer queue, bound to the top level.
// Depends on dotq_pkg and deadline_ordered_timer_queue.
`timescale 1ns / 1ps

module dotq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          valid_o,
  input logic [dotq_pkg::KIND_W-1:0]   kind_o,
  input logic [dotq_pkg::TAG_W-1:0]    due_tag_o,
  input logic [dotq_pkg::PEND_W-1:0]   pending_count_o,
  input logic                          is_last_o
);
  import dotq_pkg::*;

  // an accepted item keeps the block busy until its results are under way
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // the final result of an item is shown with the block already free
  a_last_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_last_o |-> !busy)
    else $error("busy still high with final result");

  // only a run of due tasks has results that are not final, and they come back to back
  a_due_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !is_last_o |-> kind_o == KIND_DUE ##1 valid_o && kind_o == KIND_DUE
      && pending_count_o == $past(pending_count_o) - PEND_W'(1))
    else $error("broken due run");

  a_clear_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == KIND_CLEARED |-> pending_count_o == '0 && due_tag_o == '0
      && is_last_o)
    else $error("cleared result with non-zero fields");

endmodule

bind deadline_ordered_timer_queue dotq_checker u_dotq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .valid_o         (valid_o),
  .kind_o          (kind_o),
  .due_tag_o       (due_tag_o),
  .pending_count_o (pending_count_o),
  .is_last_o       (is_last_o)
);
